// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BBX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BBX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BBX_ASSERT_IMP(lbl, ante, cons, msg)
`define BBX_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/bbx_pkg.sv =====
// ----------------------------------------------------------------------------
// Box blur package
// Shared types, constants and the divide-by-nine helper of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bbx_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_W          = 11;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;
    localparam int REG_IDX_LSB    = 2;
    localparam int DIM_MIN        = 3;
    localparam int RESET_WIDTH    = 8;
    localparam int RESET_HEIGHT   = 6;

    localparam int CH_W           = 8;
    localparam int SUM_W          = 12;
    localparam int RECIP_W        = 13;
    localparam int PROD_W         = SUM_W + RECIP_W;
    localparam int DIV9_SHIFT     = 16;
    localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CH_W-1:0] pix_red;
        logic [CH_W-1:0] pix_green;
        logic [CH_W-1:0] pix_blue;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] blur_red;
        logic [CH_W-1:0] blur_green;
        logic [CH_W-1:0] blur_blue;
        logic            frame_last;
    } t_blur_out;

    typedef struct packed {
        logic [CFG_W-1:0] w_last;
        logic [CFG_W-1:0] h_last;
    } t_dims;

    typedef struct packed {
        logic shift;
        logic sum_en;
    } t_win_ctl;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sums;

    // Exact floor(s / 9) for every s up to 2303, which covers every nine-pixel sum.
    function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * PROD_W'(DIV9_RECIP);
        return p[DIV9_SHIFT +: CH_W];
    endfunction

endpackage

// ===== src/bbx_cfg.sv =====
// ----------------------------------------------------------------------------
// Box blur configuration registers
// APB register file for the frame size, with the clamped last indices.
// ----------------------------------------------------------------------------
module bbx_cfg #(
    parameter int MAX_WIDTH  = bbx_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbx_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bbx_pkg::APB_AW-1:0]  paddr,
    input  logic [bbx_pkg::APB_DW-1:0]  pwdata,
    output logic [bbx_pkg::APB_DW-1:0]  o_prdata,
    output bbx_pkg::t_dims              o_dims
);

    function automatic logic [bbx_pkg::CFG_W-1:0] last_idx(
        input logic [bbx_pkg::CFG_W-1:0] v,
        input int                        maxv
    );
        logic [bbx_pkg::CFG_W-1:0] c;
        priority if (int'(v) < bbx_pkg::DIM_MIN) begin
            c = bbx_pkg::CFG_W'(bbx_pkg::DIM_MIN);
        end else if (int'(v) > maxv) begin
            c = bbx_pkg::CFG_W'(maxv);
        end else begin
            c = v;
        end
        return c - bbx_pkg::CFG_W'(1);
    endfunction

    logic [bbx_pkg::CFG_W-1:0] r_width;
    logic [bbx_pkg::CFG_W-1:0] r_height;
    bbx_pkg::t_dims            r_dims;
    logic                      wr;
    bbx_pkg::t_reg_idx         idx;
    logic [bbx_pkg::CFG_W-1:0] wval;

    assign wr   = psel && penable && pwrite;
    assign idx  = bbx_pkg::t_reg_idx'(paddr[bbx_pkg::REG_IDX_LSB]);
    assign wval = pwdata[bbx_pkg::CFG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= bbx_pkg::CFG_W'(bbx_pkg::RESET_WIDTH);
            r_height      <= bbx_pkg::CFG_W'(bbx_pkg::RESET_HEIGHT);
            r_dims.w_last <= last_idx(bbx_pkg::CFG_W'(bbx_pkg::RESET_WIDTH), MAX_WIDTH);
            r_dims.h_last <= last_idx(bbx_pkg::CFG_W'(bbx_pkg::RESET_HEIGHT), MAX_HEIGHT);
        end else if (wr) begin
            unique case (idx)
                bbx_pkg::REG_FRAME_WIDTH: begin
                    r_width       <= wval;
                    r_dims.w_last <= last_idx(wval, MAX_WIDTH);
                end
                bbx_pkg::REG_FRAME_HEIGHT: begin
                    r_height      <= wval;
                    r_dims.h_last <= last_idx(wval, MAX_HEIGHT);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            bbx_pkg::REG_FRAME_WIDTH:  o_prdata = bbx_pkg::APB_DW'(r_width);
            bbx_pkg::REG_FRAME_HEIGHT: o_prdata = bbx_pkg::APB_DW'(r_height);
            default:                   o_prdata = '0;
        endcase
    end

    assign o_dims = r_dims;

endmodule

// ===== src/bbx_line_ram.sv =====
// ----------------------------------------------------------------------------
// Box blur line store
// One-row pixel memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bbx_line_ram #(
    parameter int DEPTH = bbx_pkg::MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  bbx_pkg::t_pix_in         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output bbx_pkg::t_pix_in         o_rdata
);

    bbx_pkg::t_pix_in mem [DEPTH];
    bbx_pkg::t_pix_in r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bbx_window.sv =====
// ----------------------------------------------------------------------------
// Box blur window
// 3x3 pixel window registers and the registered per-channel nine-pixel sums.
// ----------------------------------------------------------------------------
module bbx_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bbx_pkg::t_win_ctl  i_ctl,
    input  bbx_pkg::t_pix_in   i_top,
    input  bbx_pkg::t_pix_in   i_mid,
    input  bbx_pkg::t_pix_in   i_pix,
    output bbx_pkg::t_sums     o_sums
);

    bbx_pkg::t_pix_in r_win [3][3];
    bbx_pkg::t_sums   r_sums;
    bbx_pkg::t_sums   sums;

    always_comb begin
        sums = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                sums.red   = sums.red   + bbx_pkg::SUM_W'(r_win[r][c].pix_red);
                sums.green = sums.green + bbx_pkg::SUM_W'(r_win[r][c].pix_green);
                sums.blue  = sums.blue  + bbx_pkg::SUM_W'(r_win[r][c].pix_blue);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_ctl.shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= i_top;
            r_win[1][2] <= i_mid;
            r_win[2][2] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_en) begin
            r_sums <= sums;
        end
    end

    assign o_sums = r_sums;

endmodule

// ===== src/rgb_box_blur_3x3.sv =====
// ----------------------------------------------------------------------------
// RGB 3x3 box blur
// Streaming 3x3 box blur over raster-order RGB pixels with two line stores.
//
//   Channel   Direction   Handshake            Payload
//   pixel     in          i_valid / o_ready    i_pix  (t_pix_in)
//   result    out         o_valid / i_ready    o_blur (t_blur_out)
//   config    in          APB psel / penable   frame_width, frame_height
//
// One pixel is accepted per clock while the result beat is not stalled. A result
// leaves through the registered line store read, window update, sum and divide stages.
// Border pixels pass through the pipe and produce no result beat.
// Reset clears the counters, the window and all stage valid bits; no memory sweep.
// A stalled result beat holds every stage, and o_ready drops in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_box_blur_3x3 #(
    parameter int MAX_WIDTH  = bbx_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbx_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  bbx_pkg::t_pix_in            i_pix,
    output logic                        o_valid,
    input  logic                        i_ready,
    output bbx_pkg::t_blur_out          o_blur,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bbx_pkg::APB_AW-1:0]  paddr,
    input  logic [bbx_pkg::APB_DW-1:0]  pwdata,
    output logic [bbx_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    typedef struct packed {
        bbx_pkg::t_pix_in pix;
        logic [AW-1:0]    col;
        logic             emit;
        logic             last;
    } t_s1;

    bbx_pkg::t_dims     dims;
    bbx_pkg::t_pix_in   mid_rd;
    bbx_pkg::t_pix_in   top_rd;
    bbx_pkg::t_sums     sums;
    bbx_pkg::t_win_ctl  win_ctl;
    bbx_pkg::t_blur_out r_out;

    logic [AW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [AW-1:0] n_col;
    logic [RW-1:0] n_row;
    t_s1           r_s1;
    logic          r_s1_v;
    logic          r_s2_v;
    logic          r_s2_last;
    logic          r_s3_v;
    logic          r_s3_last;
    logic          r_out_v;
    logic          en;
    logic          acc;
    logic          row_end;
    logic          frame_end;
    logic          emit;
    logic          s1_adv;

    bbx_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .o_prdata (prdata),
        .o_dims   (dims)
    );

    assign pready = 1'b1;

    assign en      = !r_out_v || i_ready;
    assign o_ready = en;
    assign acc     = i_valid && en;
    assign s1_adv  = r_s1_v && en;

    assign row_end   = int'(r_col) >= int'(dims.w_last);
    assign frame_end = row_end && (int'(r_row) >= int'(dims.h_last));
    assign emit      = (int'(r_row) >= 2) && (int'(r_col) >= 2);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (acc) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s2_last <= 1'b0;
            r_s3_v    <= 1'b0;
            r_s3_last <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (en) begin
                r_s1_v    <= acc;
                r_s2_v    <= r_s1_v && r_s1.emit;
                r_s2_last <= r_s1.last;
                r_s3_v    <= r_s2_v;
                r_s3_last <= r_s2_last;
                r_out_v   <= r_s3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1.pix  <= i_pix;
            r_s1.col  <= r_col;
            r_s1.emit <= emit;
            r_s1.last <= frame_end;
        end
        if (en && r_s3_v) begin
            r_out.blur_red   <= bbx_pkg::div9(sums.red);
            r_out.blur_green <= bbx_pkg::div9(sums.green);
            r_out.blur_blue  <= bbx_pkg::div9(sums.blue);
            r_out.frame_last <= r_s3_last;
        end
    end

    bbx_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1.col),
        .i_wdata (r_s1.pix),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (mid_rd)
    );

    bbx_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1.col),
        .i_wdata (mid_rd),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (top_rd)
    );

    assign win_ctl.shift  = s1_adv;
    assign win_ctl.sum_en = en;

    bbx_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (win_ctl),
        .i_top   (top_rd),
        .i_mid   (mid_rd),
        .i_pix   (r_s1.pix),
        .o_sums  (sums)
    );

    assign o_valid = r_out_v;
    assign o_blur  = r_out;

    `BBX_ASSERT_NXT(a_col_wrap, acc && row_end, r_col == '0, "Column count did not wrap.")
    `BBX_ASSERT_IMP(a_stall_blocks, r_out_v && !i_ready, !o_ready, "Input taken during stall.")
    `BBX_ASSERT_IMP(a_last_interior, r_s1_v && r_s1.last, r_s1.emit, "Frame end on a border.")

endmodule

// ===== tb/sv/blur_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur result checker
// Watches the pixel, result and register channels of the 3x3 box blur. It
// keeps its own line stores, window and position counters, works out
// the blurred beat each accepted interior pixel must produce, and
// compares every result beat field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module blur_checker
    import bbx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                pix_valid,
    input  logic                pix_ready,
    input  t_pix_in             pix,
    input  logic                blur_valid,
    input  logic                blur_ready,
    input  t_blur_out           blur,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output int                  mismatches,
    output int                  pending,
    output int                  col_pos,
    output int                  row_pos,
    output int                  width_eff,
    output int                  height_eff,
    output int                  blur_beats,
    output int                  frames_done
);

    t_pix_in          row_one_up [MAX_WIDTH_DEF];
    t_pix_in          row_two_up [MAX_WIDTH_DEF];
    t_pix_in          win [3][3];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    t_blur_out        blur_due_q [$];
    int               err_cnt;
    int               beat_cnt;
    int               frame_cnt;

    initial begin
        mismatches  = 0;
        pending     = 0;
        col_pos     = 0;
        row_pos     = 0;
        width_eff   = RESET_WIDTH;
        height_eff  = RESET_HEIGHT;
        blur_beats  = 0;
        frames_done = 0;
        err_cnt     = 0;
        beat_cnt    = 0;
        frame_cnt   = 0;
    end

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
        if (v < DIM_MIN) begin
            return DIM_MIN;
        end
        if (v > lim) begin
            return lim;
        end
        return v;
    endfunction

    task automatic note_mismatch(input string field, input int unsigned exp_v,
                                 input int unsigned act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        err_cnt++;
    endtask

    task automatic predict_blur(input t_pix_in px);
        t_pix_in     above2;
        t_pix_in     above1;
        int unsigned w;
        int unsigned h;
        int unsigned sum_r;
        int unsigned sum_g;
        int unsigned sum_b;
        logic        row_end;
        logic        frame_end;
        t_blur_out   res;
        w      = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h      = clamp_dim(height_reg, MAX_HEIGHT_DEF);
        above2 = '0;
        above1 = '0;
        if (col_cnt < MAX_WIDTH_DEF) begin
            above2 = row_two_up[col_cnt];
            above1 = row_one_up[col_cnt];
            row_two_up[col_cnt] = above1;
            row_one_up[col_cnt] = px;
        end
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = above2;
        win[1][2] = above1;
        win[2][2] = px;
        row_end   = (col_cnt >= w - 1);
        frame_end = row_end && (row_cnt >= h - 1);
        if (row_cnt >= 2 && col_cnt >= 2) begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    sum_r += win[r][c].pix_red;
                    sum_g += win[r][c].pix_green;
                    sum_b += win[r][c].pix_blue;
                end
            end
            res.blur_red   = CH_W'(sum_r / 9);
            res.blur_green = CH_W'(sum_g / 9);
            res.blur_blue  = CH_W'(sum_b / 9);
            res.frame_last = frame_end;
            blur_due_q.push_back(res);
        end
        if (row_end) begin
            col_cnt = 0;
            row_cnt = frame_end ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_blur_out want;
        if (!i_rst_n) begin
            col_cnt    = 0;
            row_cnt    = 0;
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win[r][c] = '0;
                end
            end
            blur_due_q.delete();
        end else begin
            if (blur_valid && blur_ready) begin
                if (blur_due_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, blur);
                    err_cnt++;
                end else begin
                    want = blur_due_q.pop_front();
                    if (blur.blur_red !== want.blur_red) begin
                        note_mismatch("blur_red", want.blur_red, blur.blur_red);
                    end
                    if (blur.blur_green !== want.blur_green) begin
                        note_mismatch("blur_green", want.blur_green, blur.blur_green);
                    end
                    if (blur.blur_blue !== want.blur_blue) begin
                        note_mismatch("blur_blue", want.blur_blue, blur.blur_blue);
                    end
                    if (blur.frame_last !== want.frame_last) begin
                        note_mismatch("frame_last", want.frame_last, blur.frame_last);
                    end
                    beat_cnt++;
                    if (want.frame_last) begin
                        frame_cnt++;
                    end
                end
            end
            if (pix_valid && pix_ready) begin
                predict_blur(pix);
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[REG_IDX_LSB]))
                    REG_FRAME_WIDTH: begin
                        width_reg = pwdata[CFG_W-1:0];
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg = pwdata[CFG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending     <= blur_due_q.size();
        mismatches  <= err_cnt;
        col_pos     <= col_cnt;
        row_pos     <= row_cnt;
        width_eff   <= clamp_dim(width_reg, MAX_WIDTH_DEF);
        height_eff  <= clamp_dim(height_reg, MAX_HEIGHT_DEF);
        blur_beats  <= beat_cnt;
        frames_done <= frame_cnt;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur testbench top
// Drives raster-order pixel frames and register writes into the 3x3 box blur
// with random gaps and result stalls, covering the smallest frame size, the
// widest row, out-of-range sizes and mid-frame size changes. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import bbx_pkg::*;

    localparam int RANDOM_PIXELS  = 1000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    t_pix_in             i_pix   = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    t_blur_out           o_blur;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int mismatches;
    int pending;
    int col_pos;
    int row_pos;
    int width_eff;
    int height_eff;
    int blur_beats;
    int frames_done;

    bit no_idle     = 1'b0;
    int pix_sent    = 0;
    int reg_writes  = 0;
    int idle_cycles = 0;

    rgb_box_blur_3x3 dut (.*);

    blur_checker blur_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .pix_valid   (i_valid),
        .pix_ready   (o_ready),
        .pix         (i_pix),
        .blur_valid  (o_valid),
        .blur_ready  (i_ready),
        .blur        (o_blur),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .pending     (pending),
        .col_pos     (col_pos),
        .row_pos     (row_pos),
        .width_eff   (width_eff),
        .height_eff  (height_eff),
        .blur_beats  (blur_beats),
        .frames_done (frames_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_pix_in rand_pixel();
        t_pix_in px;
        case ($urandom_range(0, 9))
            0: px = '0;
            1: px = '1;
            default: px = 24'($urandom());
        endcase
        return px;
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return CFG_W'($urandom_range(0, 2));
        end
        if (r == 1) begin
            return CFG_W'(DIM_MIN);
        end
        if (r == 2) begin
            return CFG_W'($urandom_range(13, 64));
        end
        return CFG_W'($urandom_range(3, 12));
    endfunction

    // Pixels still needed to close the frame at the current position.
    function automatic int frame_rest();
        int row_left;
        row_left = (col_pos >= width_eff - 1) ? 1 : width_eff - col_pos;
        if (row_pos >= height_eff - 1) begin
            return row_left;
        end
        return row_left + (height_eff - 1 - row_pos) * width_eff;
    endfunction

    task automatic push_pixel(input t_pix_in px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix   <= px;
        do @(posedge i_clk); while (!o_ready);
        pix_sent++;
    endtask

    task automatic send_pixels(input int count);
        for (int n = 0; n < count; n++) begin
            push_pixel(rand_pixel());
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << REG_IDX_LSB;
        pwdata  <= ($urandom() & ~32'h0000_07FF) | APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
    endtask

    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                i_ready <= 1'b0;
                hold--;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 9) == 0) begin
                    hold = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int      rest;
        int      random_start;
        t_pix_in px;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sizes below the minimum act as the smallest 3x3 frame.
        write_reg(REG_FRAME_WIDTH, CFG_W'(2));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(0));
        repeat (9) push_pixel('1);
        for (int k = 0; k < 9; k++) begin
            px = (k % 2 == 1) ? {8'h55, 8'hAA, 8'h00} : {8'hAA, 8'h55, 8'hFF};
            push_pixel(px);
        end
        wait_idle();

        // An oversized width acts as the widest row; the frame is closed
        // after the width shrinks early in its second row.
        write_reg(REG_FRAME_WIDTH, CFG_W'(2047));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
        send_pixels(MAX_WIDTH_DEF + 2);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(DIM_MIN));
        send_pixels(frame_rest());
        wait_idle();

        random_start = pix_sent;
        while (pix_sent - random_start < RANDOM_PIXELS) begin
            wait_idle();
            no_idle = ($urandom_range(0, 4) == 0);
            if (col_pos == 0 && row_pos == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    write_reg(REG_FRAME_WIDTH, pick_dim());
                end
                if ($urandom_range(0, 3) != 0) begin
                    write_reg(REG_FRAME_HEIGHT, pick_dim());
                end
            end else if ($urandom_range(0, 1) == 0) begin
                // Mid-frame the width only shrinks, so every line store
                // entry read later was filled earlier in the frame.
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(0, width_eff)));
                end else begin
                    write_reg(REG_FRAME_HEIGHT, pick_dim());
                end
            end
            rest = frame_rest();
            if (rest > 1 && $urandom_range(0, 3) == 0) begin
                send_pixels($urandom_range(1, rest - 1));
            end else if (width_eff * height_eff <= 200) begin
                send_pixels(rest + $urandom_range(0, 2) * width_eff * height_eff);
            end else begin
                send_pixels(rest);
            end
        end

        no_idle = 1'b0;
        wait_idle();
        $display("Sent %0d pixel beats and %0d register writes; checked %0d blurred beats,",
                 pix_sent, reg_writes, blur_beats);
        $display("%0d frames from 3x3 up to 64x64, one 1024-pixel row, mid-frame size changes.",
                 frames_done);
        if (mismatches == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
